// ===== rtl/core/rps_pkg.sv =====
// Shared types and constants for the radius point suppression block.
package rps_pkg;

	localparam int COORD_W = 12;            // coordinate field width on the ports
	localparam int THR_W   = 12;            // distance threshold register width
	localparam int LIM_W   = 2 * THR_W;     // squared threshold width
	localparam int KCNT_W  = 7;             // reported kept count width
	localparam int REG_W   = 1;             // register index width (byte address bit 2)

	localparam logic [THR_W-1:0] THR_RESET = 12'd16;

	// register indexes
	localparam logic [REG_W-1:0] REG_DISTANCE_THRESHOLD = 1'b0;

	typedef struct packed {
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic               start_set;
	} point_t;

	typedef struct packed {
		logic              keep;
		logic              overflow;
		logic [KCNT_W-1:0] kept_count;
	} result_t;

	// one distance test coming out of the compare pipeline
	typedef struct packed {
		logic valid;
		logic close;
	} dist_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/radius_point_suppression.sv =====
// Top level: point sequencer, kept-point table, threshold register and result register.
//
// Points come in on the point channel (valid/ready) and each one yields exactly one
// beat on the result channel: keep, overflow and the kept count after that point.
// The point is compared against every point kept so far in the current set; the
// stored points are read from the table RAM one per cycle and run through a
// three-stage distance pipeline (abs diff, square, sum and compare).
// A point with start_set high empties the table first.
// The scan runs until all N stored points have come back from the distance pipeline,
// N being the kept count seen by the point; a close match stops the scan early.
// A new point is accepted only after the result of the last one is registered.
// The result sits in an output register; the next point is accepted and scanned
// while it waits. If the receiver stalls, the block holds the finished result of
// the following point until the register is free, and takes no further point.
// distance_threshold is written over the APB port at byte address 0 (reset 16);
// a threshold of zero keeps every point while the table has room. Reset empties the
// table, clears result_valid and restores the threshold; no clearing pass is needed.
module radius_point_suppression #(
	parameter int MAX_KEPT   = 64,
	parameter int COORD_BITS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              point_valid,
	output logic              point_ready,
	input  rps_pkg::point_t   point,
	output logic              result_valid,
	input  logic              result_ready,
	output rps_pkg::result_t  result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int CW    = COORD_BITS;
	localparam int AW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W = $clog2(MAX_KEPT + 1);
	localparam int PW    = rps_pkg::COORD_W;
	localparam int KW    = rps_pkg::KCNT_W;

	rps_pkg::state_t state_q, state_d;

	logic [rps_pkg::THR_W-1:0] thr_q;
	logic [rps_pkg::LIM_W-1:0] limit_q;
	logic [CNT_W-1:0]          count_q, issue_q, ret_q, cnt_next;
	logic                      hit_q;
	logic [CW-1:0]             px_q, py_q, px_in, py_in;
	logic [CW+PW-1:0]          px_ext, py_ext;
	logic [CNT_W+KW-1:0]       cnt_ext;
	logic                      result_valid_q;
	rps_pkg::result_t          result_q;

	logic accept, re, flush, finish, store, slot_free, room, cfg_wr;
	logic [2*CW-1:0] rdata;
	rps_pkg::dist_res_t res;

	// coordinates masked or widened to the table width
	assign px_ext = {{CW{1'b0}}, point.point_x};
	assign py_ext = {{CW{1'b0}}, point.point_y};
	assign px_in  = px_ext[CW-1:0];
	assign py_in  = py_ext[CW-1:0];

	assign slot_free = ~result_valid_q | result_ready;
	assign room      = count_q < CNT_W'(MAX_KEPT);
	assign accept    = point_valid & point_ready;

	always_comb begin
		state_d     = state_q;
		point_ready = 1'b0;
		re          = 1'b0;
		flush       = 1'b0;
		finish      = 1'b0;
		unique case (state_q)
			rps_pkg::ST_IDLE: begin
				point_ready = 1'b1;
				if (point_valid) begin
					state_d = rps_pkg::ST_SCAN;
				end
			end
			rps_pkg::ST_SCAN: begin
				if (hit_q || ret_q == count_q) begin
					state_d = rps_pkg::ST_DONE;
				end else begin
					re = issue_q != count_q;
				end
			end
			rps_pkg::ST_DONE: begin
				flush = 1'b1;  // drop reads still in flight after an early hit
				if (slot_free) begin
					finish  = 1'b1;
					state_d = rps_pkg::ST_IDLE;
				end
			end
			default: state_d = rps_pkg::ST_IDLE;
		endcase
	end

	assign store    = finish & ~hit_q & room;
	assign cnt_next = count_q + CNT_W'(store);
	assign cnt_ext  = {{KW{1'b0}}, cnt_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= rps_pkg::ST_IDLE;
			count_q        <= '0;
			issue_q        <= '0;
			ret_q          <= '0;
			hit_q          <= 1'b0;
			result_valid_q <= 1'b0;
			thr_q          <= rps_pkg::THR_RESET;
		end else begin
			state_q <= state_d;
			if (accept) begin
				issue_q <= '0;
				ret_q   <= '0;
				hit_q   <= 1'b0;
				if (point.start_set) begin
					count_q <= '0;
				end
			end
			if (re) begin
				issue_q <= issue_q + 1'b1;
			end
			if (state_q == rps_pkg::ST_SCAN && res.valid) begin
				ret_q <= ret_q + 1'b1;
				if (res.close) begin
					hit_q <= 1'b1;
				end
			end
			if (store) begin
				count_q <= cnt_next;
			end
			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				thr_q <= pwdata[rps_pkg::THR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q    <= px_in;
			py_q    <= py_in;
			limit_q <= rps_pkg::LIM_W'(thr_q) * rps_pkg::LIM_W'(thr_q);
		end
		if (finish) begin
			result_q.keep       <= store;
			result_q.overflow   <= ~hit_q & ~room;
			result_q.kept_count <= cnt_ext[KW-1:0];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// APB register port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite
		& (paddr[2] == rps_pkg::REG_DISTANCE_THRESHOLD);

	always_comb begin
		prdata = '0;
		if (paddr[2] == rps_pkg::REG_DISTANCE_THRESHOLD) begin
			prdata = {{(32 - rps_pkg::THR_W){1'b0}}, thr_q};
		end
	end

	rps_ram #(
		.WIDTH (2 * CW),
		.DEPTH (MAX_KEPT)
	) u_table (
		.clk   (clk),
		.we    (store),
		.waddr (count_q[AW-1:0]),
		.wdata ({px_q, py_q}),
		.re    (re),
		.raddr (issue_q[AW-1:0]),
		.rdata (rdata)
	);

	rps_dist #(
		.COORD_BITS (CW)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (re),
		.flush  (flush),
		.px     (px_q),
		.py     (py_q),
		.limit  (limit_q),
		.rdata  (rdata),
		.res    (res)
	);

endmodule

// ===== rtl/core/rps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/rps_dist.sv =====
// Pipelined squared-distance test of the current point against one stored point per cycle.
module rps_dist #(
	parameter int COORD_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      re,
	input  logic                      flush,
	input  logic [COORD_BITS-1:0]     px,
	input  logic [COORD_BITS-1:0]     py,
	input  logic [rps_pkg::LIM_W-1:0] limit,
	input  logic [2*COORD_BITS-1:0]   rdata,
	output rps_pkg::dist_res_t        res
);

	localparam int CW    = COORD_BITS;
	localparam int SQ_W  = 2 * CW;
	localparam int SUM_W = SQ_W + 1;
	localparam int CMP_W = (SUM_W > rps_pkg::LIM_W) ? SUM_W : rps_pkg::LIM_W;

	logic            v_s1, v_s2, v_s3;
	logic [CW-1:0]   kx, ky, dx, dy;
	logic [CW-1:0]   dx_s2, dy_s2;
	logic [SQ_W-1:0] sqx_s3, sqy_s3;
	logic [SUM_W-1:0] sum;

	assign kx = rdata[2*CW-1:CW];
	assign ky = rdata[CW-1:0];
	assign dx = (px >= kx) ? (px - kx) : (kx - px);
	assign dy = (py >= ky) ? (py - ky) : (ky - py);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= re & ~flush;
			v_s2 <= v_s1 & ~flush;
			v_s3 <= v_s2 & ~flush;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= dx;
		dy_s2  <= dy;
		sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3 <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
	end

	assign sum       = SUM_W'(sqx_s3) + SUM_W'(sqy_s3);
	assign res.valid = v_s3;
	assign res.close = CMP_W'(sum) < CMP_W'(limit);

endmodule
